/* hdl/vuc_pkg.sv */
// shared types and constants for the vector uop cracker
package vuc_pkg;

  localparam int VECTOR_BITS_DEF = 128;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [2:0] {
    KIND_ELEM         = 3'd0,
    KIND_SINGLE_DEST  = 3'd1,
    KIND_WIDEN        = 3'd2,
    KIND_WIDEN_MIXED  = 3'd3,
    KIND_MAC          = 3'd4,
    KIND_MAC_WIDE     = 3'd5,
    KIND_NARROW       = 3'd6,
    KIND_INT_EXT      = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    DOFF_NONE,
    DOFF_FULL,
    DOFF_HALF
  } dest_off_t;

  typedef struct packed {
    logic [2:0] uop_kind;
    logic [4:0] dest_reg;
    logic [4:0] src1_reg;
    logic       src1_is_vector;
    logic [4:0] src2_reg;
    logic       src2_is_vector;
    logic [1:0] lmul_log2;
    logic [1:0] sew_log2;
    logic [7:0] vec_length;
    logic [1:0] ext_log2;
  } instr_t;

  typedef struct packed {
    logic [4:0] uop_dest;
    logic [4:0] uop_src1;
    logic [4:0] uop_src2;
    logic [4:0] uop_src3;
    logic       src3_valid;
    logic [2:0] uop_index;
    logic       tail_flag;
    logic       last_uop;
    logic       group_error;
  } uop_t;

  typedef struct packed {
    logic       err;
    logic       mac;
    logic [2:0] cnt_m1;
    dest_off_t  dest_off;
    logic [1:0] src1_sh;
    logic [1:0] src2_sh;
    logic [4:0] dest_base;
    logic [4:0] src1_base;
    logic       src1_vec;
    logic [4:0] src2_base;
    logic       src2_vec;
    logic [1:0] sew_log2;
    logic [7:0] vec_length;
  } dec_t;

endpackage

/* hdl/vuc_front.sv */
// front end: takes instructions and classifies them into queue entries
module vuc_front (
  input  logic            start,
  input  vuc_pkg::instr_t instr,
  input  logic            q_full,
  output logic            busy,
  output logic            push,
  output vuc_pkg::dec_t   push_data
);
  import vuc_pkg::*;

  logic       dbl;
  logic [2:0] grp_log2;
  logic [3:0] cnt;

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    push_data            = '0;
    push_data.dest_base  = instr.dest_reg;
    push_data.src1_base  = instr.src1_reg;
    push_data.src1_vec   = instr.src1_is_vector;
    push_data.src2_base  = instr.src2_reg;
    push_data.src2_vec   = instr.src2_is_vector;
    push_data.sew_log2   = instr.sew_log2;
    push_data.vec_length = instr.vec_length;
    dbl                  = 1'b0;
    unique case (kind_t'(instr.uop_kind))
      KIND_ELEM: begin
        push_data.dest_off = DOFF_FULL;
      end
      KIND_SINGLE_DEST: begin
        push_data.dest_off = DOFF_NONE;
      end
      KIND_WIDEN: begin
        push_data.dest_off = DOFF_FULL;
        push_data.src1_sh  = 2'd1;
        push_data.src2_sh  = 2'd1;
        dbl                = 1'b1;
      end
      KIND_WIDEN_MIXED: begin
        push_data.dest_off = DOFF_FULL;
        push_data.src1_sh  = 2'd1;
        dbl                = 1'b1;
      end
      KIND_MAC: begin
        push_data.dest_off = DOFF_FULL;
        push_data.mac      = 1'b1;
      end
      KIND_MAC_WIDE: begin
        push_data.dest_off = DOFF_FULL;
        push_data.src1_sh  = 2'd1;
        push_data.src2_sh  = 2'd1;
        push_data.mac      = 1'b1;
        dbl                = 1'b1;
      end
      KIND_NARROW: begin
        push_data.dest_off = DOFF_HALF;
        push_data.src1_sh  = 2'd1;
        dbl                = 1'b1;
      end
      KIND_INT_EXT: begin
        push_data.dest_off = DOFF_FULL;
        push_data.src1_sh  = instr.ext_log2;
        push_data.src2_sh  = instr.ext_log2;
      end
      default: begin
        push_data.dest_off = DOFF_FULL;
      end
    endcase
    grp_log2 = {1'b0, instr.lmul_log2} + {2'b00, dbl};
    cnt      = 4'd1 << grp_log2;
    push_data.cnt_m1 = 3'(cnt - 4'd1);
    // group too large: one error uop
    if (dbl && instr.lmul_log2 == 2'd3) begin
      push_data.err    = 1'b1;
      push_data.cnt_m1 = '0;
    end
  end

endmodule

/* hdl/vuc_queue.sv */
// short flop queue between front and back
module vuc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vuc_pkg::dec_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output vuc_pkg::dec_t head
);
  import vuc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dec_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

/* hdl/vuc_back.sv */
// back end: sequences one uop per cycle from the current queue entry
module vuc_back #(
  parameter int VECTOR_BITS = vuc_pkg::VECTOR_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  vuc_pkg::dec_t head,
  output logic          pop,
  output logic          uop_valid,
  output vuc_pkg::uop_t uop
);
  import vuc_pkg::*;

  localparam int EPU_MAX = VECTOR_BITS / 8;
  localparam int EW      = $clog2(EPU_MAX + 1);
  localparam int PW      = EW + 4;
  localparam int MW      = (PW > 8) ? PW : 8;

  logic          active;
  dec_t          cur;
  logic [2:0]    k;
  logic          last;
  logic [2:0]    off_d;
  logic [2:0]    off_1;
  logic [2:0]    off_2;
  logic [4:0]    dest_n;
  logic [EW-1:0] epu;
  logic [PW-1:0] prod;
  uop_t          uop_next;

  assign last = (k == cur.cnt_m1);
  assign pop  = !q_empty && (!active || last);

  always_comb begin
    unique case (cur.dest_off)
      DOFF_NONE: off_d = '0;
      DOFF_HALF: off_d = k >> 1;
      default:   off_d = k;
    endcase
    off_1  = k >> cur.src1_sh;
    off_2  = k >> cur.src2_sh;
    dest_n = cur.dest_base + {2'b00, off_d};
    epu    = EW'(EPU_MAX) >> cur.sew_log2;
    prod   = PW'(epu) * PW'({1'b0, k} + 4'd1);
    uop_next             = '0;
    uop_next.last_uop    = last;
    if (cur.err) begin
      uop_next.group_error = 1'b1;
    end else begin
      uop_next.uop_dest   = dest_n;
      uop_next.uop_src1   = cur.src1_vec ? cur.src1_base + {2'b00, off_1} : cur.src1_base;
      uop_next.uop_src2   = cur.src2_vec ? cur.src2_base + {2'b00, off_2} : cur.src2_base;
      uop_next.uop_src3   = cur.mac ? dest_n : '0;
      uop_next.src3_valid = cur.mac;
      uop_next.uop_index  = k;
      uop_next.tail_flag  = MW'(prod) > MW'(cur.vec_length);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    uop <= uop_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      k         <= '0;
      uop_valid <= 1'b0;
    end else begin
      uop_valid <= active;
      if (pop) begin
        active <= 1'b1;
        k      <= '0;
      end else if (active) begin
        if (last) begin
          active <= 1'b0;
        end else begin
          k <= k + 3'd1;
        end
      end
    end
  end

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    uop_valid && uop.group_error |-> uop.last_uop && uop.uop_index == '0)
    else $error("error uop not alone");
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    uop_valid && !uop.last_uop |=>
      uop_valid && uop.uop_index == 3'($past(uop.uop_index) + 3'd1))
    else $error("uop run broken");
  a_src3_matches: assert property (@(posedge clk) disable iff (rst)
    uop_valid && uop.src3_valid |-> uop.uop_src3 == uop.uop_dest)
    else $error("third source differs from destination");

endmodule

/* hdl/vector_uop_cracker.sv */
// top level of the vector uop cracker
//
//   channel   signals                 transfer
//   command   start, busy, instr      rising edge with start high and busy low
//   result    uop_valid, uop          every edge that ends a cycle with uop_valid high
//
// an instruction yields one to eight uops, one per cycle, set by the back end sequencer
// uops are registered behind the queue and the current entry register; a two-entry
// queue between the decoder and the sequencer takes further commands while a run is
// under way; busy is high while the queue is full; results cannot be held off
// synchronous reset empties the queue and stops any run
module vector_uop_cracker #(
  parameter int VECTOR_BITS = vuc_pkg::VECTOR_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  vuc_pkg::instr_t instr,
  output logic            busy,
  output logic            uop_valid,
  output vuc_pkg::uop_t   uop
);
  import vuc_pkg::*;

  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  dec_t push_data;
  dec_t head;

  vuc_front u_front (
    .start     (start),
    .instr     (instr),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  vuc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  vuc_back #(
    .VECTOR_BITS (VECTOR_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .uop_valid (uop_valid),
    .uop       (uop)
  );

endmodule
